FILE: hw/rtl/tksl_pkg.sv
// ----------------------------------------------------------------------------
// Top-K sorted score list: shared types and constants
// Field widths, operation codes, controller states and the structs that
// travel between the controller and the list cells.
// ----------------------------------------------------------------------------
`default_nettype none

package tksl_pkg;

  localparam int unsigned MOVE_W  = 15;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned RANK_W  = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned KEEP_W  = 9;
  localparam int unsigned SPAN    = 65535;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_OFFER = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  typedef struct packed {
    logic                      valid;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    logic                      clear;
    logic                      update;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
  } ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/top_k_sorted_score_list.sv
// ----------------------------------------------------------------------------
// Top-K sorted score list
// Keeps (move, score) pairs sorted best first in a chain of cells and
// tracks the acceptance threshold: the K-th best score, else the best minus SPAN.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload
//  input     in_valid_i / in_ready_o    operation_i, move_i, score_i
//  output    out_valid_o / out_ready_i  accepted_o, rank_o, threshold_o,
//                                       best_move_o, best_score_o, entry_count_o
//  config    keep_count_we_i            keep_count_i
//
// An item is registered at its transfer, the cells compare and shift in the
// next cycle, and the threshold and result are formed in the cycle after.
// A new item is taken only once the previous result has moved to the output.
// A stalled output holds the item in the final stage until the result moves.
// Reset empties the list, sets the threshold to minus the mate value and K to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_sorted_score_list #(
  parameter int unsigned LIST_DEPTH = 256,
  parameter int unsigned MATE_VALUE = 32000
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic                                   operation_i,
  input  wire logic [tksl_pkg::MOVE_W-1:0]            move_i,
  input  wire logic signed [tksl_pkg::SCORE_W-1:0]    score_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic                                        accepted_o,
  output logic [tksl_pkg::RANK_W-1:0]                 rank_o,
  output logic signed [tksl_pkg::SCORE_W-1:0]         threshold_o,
  output logic [tksl_pkg::MOVE_W-1:0]                 best_move_o,
  output logic signed [tksl_pkg::SCORE_W-1:0]         best_score_o,
  output logic [tksl_pkg::COUNT_W-1:0]                entry_count_o,
  input  wire logic                                   keep_count_we_i,
  input  wire logic [tksl_pkg::KEEP_W-1:0]            keep_count_i
);

  localparam int unsigned IDX_W  = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned WIDE_W = tksl_pkg::SCORE_W + 2;
  localparam logic signed [tksl_pkg::SCORE_W-1:0] NegMate =
    tksl_pkg::SCORE_W'(-$signed(MATE_VALUE));
  localparam logic signed [WIDE_W-1:0] NegMateWide = WIDE_W'(-$signed(MATE_VALUE));

  tksl_pkg::state_e state_q, state_d;

  logic                                 op_q;
  logic [tksl_pkg::MOVE_W-1:0]          cand_move_q;
  logic signed [tksl_pkg::SCORE_W-1:0]  cand_score_q;
  logic [tksl_pkg::KEEP_W-1:0]          keep_q;
  logic [CNT_W-1:0]                     count_q;
  logic signed [tksl_pkg::SCORE_W-1:0]  thr_q;
  logic                                 acc_q;
  logic [IDX_W-1:0]                     rank_q;

  logic                                 out_valid_q;
  logic                                 out_acc_q;
  logic [tksl_pkg::RANK_W-1:0]          out_rank_q;
  logic signed [tksl_pkg::SCORE_W-1:0]  out_thr_q;
  logic [tksl_pkg::MOVE_W-1:0]          out_move_q;
  logic signed [tksl_pkg::SCORE_W-1:0]  out_score_q;
  logic [tksl_pkg::COUNT_W-1:0]         out_count_q;

  tksl_pkg::ctrl_t   ctrl;
  tksl_pkg::entry_t  cells    [LIST_DEPTH];
  tksl_pkg::entry_t  prev_e   [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] ge;
  logic [LIST_DEPTH-1:0] prev_ge;
  logic [LIST_DEPTH-1:0] ins;

  logic                                 in_xfer;
  logic                                 offer_ok;
  logic                                 out_free;
  logic [IDX_W-1:0]                     rank_enc;
  logic [tksl_pkg::KEEP_W-1:0]          k_sat;
  logic [IDX_W-1:0]                     k_idx;
  logic signed [WIDE_W-1:0]             diff;
  logic signed [tksl_pkg::SCORE_W-1:0]  thr_new;
  logic signed [tksl_pkg::SCORE_W-1:0]  best_score;
  logic [tksl_pkg::MOVE_W-1:0]          best_move;

  assign in_ready_o = (state_q == tksl_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign offer_ok = ($signed(cand_score_q) > $signed(thr_q)) && !ge[LIST_DEPTH-1];

  assign ctrl.clear  = (state_q == tksl_pkg::ST_CMP) && (op_q == tksl_pkg::OP_CLEAR);
  assign ctrl.update = (state_q == tksl_pkg::ST_CMP) && (op_q == tksl_pkg::OP_OFFER)
                       && offer_ok;
  assign ctrl.move   = cand_move_q;
  assign ctrl.score  = cand_score_q;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_e[i]  = '{valid: 1'b1, move: '0, score: '0};
      assign prev_ge[i] = 1'b1;
    end else begin : g_link
      assign prev_e[i]  = cells[i-1];
      assign prev_ge[i] = ge[i-1];
    end

    assign ins[i] = prev_ge[i] && !ge[i];

    tksl_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .prev_i    (prev_e[i]),
      .prev_ge_i (prev_ge[i]),
      .entry_o   (cells[i]),
      .ge_o      (ge[i])
    );
  end

  always_comb begin
    rank_enc = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (ins[i]) begin
        rank_enc = rank_enc | IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (keep_q == '0) begin
      k_sat = tksl_pkg::KEEP_W'(1);
    end else if (keep_q > tksl_pkg::KEEP_W'(LIST_DEPTH)) begin
      k_sat = tksl_pkg::KEEP_W'(LIST_DEPTH);
    end else begin
      k_sat = keep_q;
    end
  end

  assign k_idx = IDX_W'(k_sat - tksl_pkg::KEEP_W'(1));

  assign best_move  = (count_q != '0) ? cells[0].move  : '0;
  assign best_score = (count_q != '0) ? cells[0].score : '0;

  always_comb begin
    diff = WIDE_W'($signed(best_score)) - WIDE_W'(tksl_pkg::SPAN);
    if (tksl_pkg::KEEP_W'(count_q) >= k_sat) begin
      thr_new = cells[k_idx].score;
    end else if ($signed(diff) < $signed(NegMateWide)) begin
      thr_new = NegMate;
    end else begin
      thr_new = diff[tksl_pkg::SCORE_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tksl_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = tksl_pkg::ST_CMP;
        end
      end
      tksl_pkg::ST_CMP: begin
        state_d = tksl_pkg::ST_FIN;
      end
      tksl_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = tksl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tksl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tksl_pkg::ST_IDLE;
      keep_q      <= tksl_pkg::KEEP_W'(1);
      count_q     <= '0;
      thr_q       <= NegMate;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (keep_count_we_i) begin
        keep_q <= keep_count_i;
      end
      if (ctrl.clear) begin
        count_q <= '0;
        thr_q   <= NegMate;
      end else if (ctrl.update && (count_q != CNT_W'(LIST_DEPTH))) begin
        count_q <= count_q + CNT_W'(1);
      end
      if ((state_q == tksl_pkg::ST_FIN) && out_free && acc_q) begin
        thr_q <= thr_new;
      end
      if ((state_q == tksl_pkg::ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q         <= operation_i;
      cand_move_q  <= move_i;
      cand_score_q <= score_i;
    end
    if (state_q == tksl_pkg::ST_CMP) begin
      acc_q  <= ctrl.update;
      rank_q <= ctrl.update ? rank_enc : '0;
    end
    if ((state_q == tksl_pkg::ST_FIN) && out_free) begin
      out_acc_q   <= acc_q;
      out_rank_q  <= tksl_pkg::RANK_W'(rank_q);
      out_thr_q   <= acc_q ? thr_new : thr_q;
      out_move_q  <= best_move;
      out_score_q <= best_score;
      out_count_q <= tksl_pkg::COUNT_W'(count_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = out_acc_q;
  assign rank_o        = out_rank_q;
  assign threshold_o   = out_thr_q;
  assign best_move_o   = out_move_q;
  assign best_score_o  = out_score_q;
  assign entry_count_o = out_count_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tksl_cell.sv
// ----------------------------------------------------------------------------
// Top-K sorted score list: list cell
// Holds one entry, compares its score with the candidate and either keeps
// its entry, takes the candidate, takes the entry of its upper neighbor or empties.
// ----------------------------------------------------------------------------
`default_nettype none

module tksl_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tksl_pkg::ctrl_t ctrl_i,
  input  wire tksl_pkg::entry_t prev_i,
  input  wire logic            prev_ge_i,
  output tksl_pkg::entry_t     entry_o,
  output logic                 ge_o
);

  tksl_pkg::entry_t entry_q, entry_d;

  assign ge_o    = entry_q.valid && ($signed(entry_q.score) >= $signed(ctrl_i.score));
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.clear) begin
      entry_d.valid = 1'b0;
    end else if (ctrl_i.update && !ge_o) begin
      if (prev_ge_i) begin
        entry_d.valid = 1'b1;
        entry_d.move  = ctrl_i.move;
        entry_d.score = ctrl_i.score;
      end else begin
        entry_d = prev_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule

`default_nettype wire

FILE: test/top_k_sorted_score_list_test.sv
// ----------------------------------------------------------------------------
// Top-K sorted score list: self-checking testbench
// Drives clear and offer items through the valid/ready input channel and
// predicts every result with a behavioral copy of the sorted list, its
// threshold and the keep count. Directed items cover ties, rejections and
// score extremes. Random phases use varied score streams and keep counts,
// and include runs long enough to fill the list. Both channels idle at
// random, and one long output stall backs the block up.
// ----------------------------------------------------------------------------
module top_k_sorted_score_list_test;
  import tksl_pkg::*;

  localparam int LIST_DEPTH    = 256;
  localparam int MATE_VALUE    = 32000;
  localparam int ITEM_TARGET   = 750;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 200000;

  typedef enum {
    SCORES_WIDE,
    SCORES_TIED,
    SCORES_RISING,
    SCORES_FALLING
  } score_mode_e;

  typedef struct packed {
    logic                      accepted;
    logic [RANK_W-1:0]         rank;
    logic signed [SCORE_W-1:0] threshold;
    logic [MOVE_W-1:0]         best_move;
    logic signed [SCORE_W-1:0] best_score;
    logic [COUNT_W-1:0]        entry_count;
  } list_result_t;

  class score_list_board;
    logic [MOVE_W-1:0]         entry_move[LIST_DEPTH];
    logic signed [SCORE_W-1:0] entry_score[LIST_DEPTH];
    int                        held;
    int                        threshold;
    logic [KEEP_W-1:0]         keep;
    list_result_t              expected_q[$];
    int                        errors;
    int                        shown;
    int                        checked;
    int                        clears;
    int                        inserted;
    int                        rejected;
    int                        overflows;

    function new();
      keep      = 1;
      errors    = 0;
      shown     = 0;
      checked   = 0;
      clears    = 0;
      inserted  = 0;
      rejected  = 0;
      overflows = 0;
      empty_list();
    endfunction

    function void empty_list();
      foreach (entry_move[i]) begin
        entry_move[i]  = '0;
        entry_score[i] = '0;
      end
      held      = 0;
      threshold = -MATE_VALUE;
    endfunction

    function int keep_in_force();
      if (keep == 0) return 1;
      if (keep > LIST_DEPTH) return LIST_DEPTH;
      return int'(keep);
    endfunction

    function void note_item(logic op, logic [MOVE_W-1:0] mv, logic signed [SCORE_W-1:0] sc);
      list_result_t res;
      int           slot;
      int           k;
      bit           fits;
      res  = '0;
      slot = 0;
      fits = 1'b0;
      if (op == OP_CLEAR) begin
        empty_list();
        clears++;
      end else begin
        if (int'(sc) > threshold) begin
          while (slot < held && entry_score[slot] >= sc) slot++;
          fits = (slot < LIST_DEPTH);
        end
        if (fits) begin
          for (int i = (held < LIST_DEPTH) ? held : LIST_DEPTH - 1; i > slot; i--) begin
            entry_move[i]  = entry_move[i-1];
            entry_score[i] = entry_score[i-1];
          end
          entry_move[slot]  = mv;
          entry_score[slot] = sc;
          if (held < LIST_DEPTH) held++;
          else overflows++;
          k = keep_in_force();
          if (held >= k) begin
            threshold = int'(entry_score[k-1]);
          end else begin
            threshold = int'(entry_score[0]) - int'(SPAN);
            if (threshold < -MATE_VALUE) threshold = -MATE_VALUE;
          end
          res.accepted = 1'b1;
          res.rank     = RANK_W'(slot);
          inserted++;
        end else begin
          rejected++;
        end
      end
      res.threshold = threshold[SCORE_W-1:0];
      if (held > 0) begin
        res.best_move  = entry_move[0];
        res.best_score = entry_score[0];
      end
      res.entry_count = COUNT_W'(held);
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (shown < 40) begin
        shown++;
        $display("ERROR: result %0d: %s", checked, what);
      end
    endtask

    task check_result(list_result_t got);
      list_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: %p", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.accepted !== want.accepted)
        report_mismatch($sformatf("accepted got %0d, expected %0d",
                                  got.accepted, want.accepted));
      if (got.rank !== want.rank)
        report_mismatch($sformatf("rank got %0d, expected %0d", got.rank, want.rank));
      if (got.threshold !== want.threshold)
        report_mismatch($sformatf("threshold got %0d, expected %0d",
                                  got.threshold, want.threshold));
      if (got.best_move !== want.best_move)
        report_mismatch($sformatf("best_move got %0d, expected %0d",
                                  got.best_move, want.best_move));
      if (got.best_score !== want.best_score)
        report_mismatch($sformatf("best_score got %0d, expected %0d",
                                  got.best_score, want.best_score));
      if (got.entry_count !== want.entry_count)
        report_mismatch($sformatf("entry_count got %0d, expected %0d",
                                  got.entry_count, want.entry_count));
      checked++;
    endtask
  endclass

  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      in_valid_i      = 1'b0;
  logic                      in_ready_o;
  logic                      operation_i     = OP_CLEAR;
  logic [MOVE_W-1:0]         move_i          = '0;
  logic signed [SCORE_W-1:0] score_i         = '0;
  logic                      out_valid_o;
  logic                      out_ready_i     = 1'b0;
  logic                      accepted_o;
  logic [RANK_W-1:0]         rank_o;
  logic signed [SCORE_W-1:0] threshold_o;
  logic [MOVE_W-1:0]         best_move_o;
  logic signed [SCORE_W-1:0] best_score_o;
  logic [COUNT_W-1:0]        entry_count_o;
  logic                      keep_count_we_i = 1'b0;
  logic [KEEP_W-1:0]         keep_count_i    = '0;

  score_list_board board;
  int              cycle_count   = 0;
  int              items_sent    = 0;
  int              burst_left    = 0;
  int              hold_requests = 0;
  int              config_writes = 0;

  top_k_sorted_score_list #(
    .LIST_DEPTH(LIST_DEPTH),
    .MATE_VALUE(MATE_VALUE)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .move_i         (move_i),
    .score_i        (score_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_o     (accepted_o),
    .rank_o         (rank_o),
    .threshold_o    (threshold_o),
    .best_move_o    (best_move_o),
    .best_score_o   (best_score_o),
    .entry_count_o  (entry_count_o),
    .keep_count_we_i(keep_count_we_i),
    .keep_count_i   (keep_count_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result({accepted_o, rank_o, threshold_o, best_move_o, best_score_o,
                          entry_count_o});
  end

  initial begin : receiver
    int holds_done;
    holds_done = 0;
    @(posedge clk_i);
    forever begin
      if (hold_requests > holds_done) begin
        holds_done++;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  function automatic logic [MOVE_W-1:0] rand_move();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return MOVE_W'($urandom_range(1, 32767));
    endcase
  endfunction

  function automatic logic signed [SCORE_W-1:0] phase_score(score_mode_e mode, int base,
                                                            int step, int n);
    int value;
    case ($urandom_range(0, 19))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'sh8001;
      3:       return '0;
      default: ;
    endcase
    case (mode)
      SCORES_TIED:    value = base + $urandom_range(0, 3);
      SCORES_RISING:  value = base + n * step;
      SCORES_FALLING: value = base - n * step;
      default:        value = $urandom_range(0, 65535);
    endcase
    return value[SCORE_W-1:0];
  endfunction

  task automatic send_item(logic op, logic [MOVE_W-1:0] mv, logic signed [SCORE_W-1:0] sc);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    move_i      <= mv;
    score_i     <= sc;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    items_sent++;
    board.note_item(op, mv, sc);
  endtask

  task automatic set_keep(int value);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    keep_count_we_i <= 1'b1;
    keep_count_i    <= KEEP_W'(value);
    @(posedge clk_i);
    keep_count_we_i <= 1'b0;
    board.keep = KEEP_W'(value);
    config_writes++;
  endtask

  task automatic run_phase(int k, int len, score_mode_e mode, int base, int step,
                           bit long_hold);
    set_keep(k);
    send_item(OP_CLEAR, rand_move(), phase_score(SCORES_WIDE, 0, 0, 0));
    if (long_hold) hold_requests++;
    for (int n = 0; n < len; n++) begin
      if (!long_hold && $urandom_range(0, 49) == 0)
        send_item(OP_CLEAR, rand_move(), phase_score(SCORES_WIDE, 0, 0, 0));
      else
        send_item(OP_OFFER, rand_move(), phase_score(mode, base, step, n));
    end
  endtask

  initial begin : stimulus
    int keep_choices[10];
    int k;
    board = new();
    keep_choices = '{0, 1, 2, 3, 5, 16, 255, 256, 257, 511};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset keep count of one: the threshold follows the best score.
    send_item(OP_OFFER, 15'h7fff, 16'sd100);
    send_item(OP_OFFER, 15'd5, 16'sd100);
    send_item(OP_OFFER, 15'd0, 16'sh7fff);
    send_item(OP_OFFER, 15'd7, 16'sh8000);
    send_item(OP_CLEAR, 15'h7fff, 16'sh7fff);
    send_item(OP_OFFER, 15'd3, 16'sh8000);
    send_item(OP_OFFER, 15'h5555, -16'sd32000);
    send_item(OP_OFFER, 15'h2aaa, -16'sd31999);

    // Ties land behind equal scores; the fourth score becomes the threshold.
    set_keep(4);
    send_item(OP_CLEAR, 15'd0, 16'sd0);
    send_item(OP_OFFER, 15'd10, 16'sd50);
    send_item(OP_OFFER, 15'd11, 16'sd50);
    send_item(OP_OFFER, 15'd12, 16'sd70);
    send_item(OP_OFFER, 15'd13, -16'sd32767);
    send_item(OP_OFFER, 15'd14, 16'sd50);
    send_item(OP_OFFER, 15'd15, 16'sd60);
    send_item(OP_OFFER, 15'd16, 16'sd50);
    send_item(OP_OFFER, 15'd17, -16'sd1);

    // A keep count of zero acts as one; a count above the depth saturates.
    set_keep(0);
    send_item(OP_OFFER, 15'h7fff, 16'sh7fff);
    send_item(OP_OFFER, 15'd1, 16'sh7fff);
    set_keep(511);
    send_item(OP_CLEAR, 15'h1234, 16'sh8000);
    send_item(OP_OFFER, 15'd9, -16'sd5);
    send_item(OP_OFFER, 15'd8, -16'sd5);

    // Overfill the list while the output is held off for a long stretch.
    run_phase(256, 300, SCORES_WIDE, 0, 0, 1'b1);
    run_phase(3, 270, SCORES_RISING, -32000, 1, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) k = $urandom_range(0, 511);
      else k = keep_choices[$urandom_range(0, 9)];
      run_phase(k, $urandom_range(4, 40), score_mode_e'($urandom_range(0, 3)),
                $urandom_range(0, 65535) - 32768, $urandom_range(1, 300), 1'b0);
    end

    in_valid_i <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);

    $display("Run covered %0d transfers: %0d clears, %0d insertions, %0d rejected offers.",
             items_sent, board.clears, board.inserted, board.rejected);
    $display("Full list pushed out its lowest entry %0d times over %0d keep_count writes.",
             board.overflows, config_writes);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches found.", board.errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
